>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros for the checker of the stack core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/bsws_pkg.sv
// ----------------------------------------------------------------------------
// bsws_pkg
// Shared types and constants of the byte stack with search.
// ----------------------------------------------------------------------------
package bsws_pkg;

   localparam int DEPTH_DEFAULT = 128;

   localparam int DATA_W      = 8;
   localparam int FIND_IDX_W  = 7;
   localparam int DEPTH_CNT_W = 8;

   // Operation carried with each input item.
   typedef enum logic [1:0] {
      OP_PUSH  = 2'd0,
      OP_POP   = 2'd1,
      OP_CLEAR = 2'd2,
      OP_FIND  = 2'd3
   } op_type;

   // Status reported with each result item.
   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2
   } status_type;

   // Sequencer states of the core.
   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_POP  = 2'd1,
      ST_FIND = 2'd2
   } state_type;

endpackage

>>> rtl/core/bsws_ram.sv
// ----------------------------------------------------------------------------
// bsws_ram
// Single-port-write, single-port-read byte memory with a registered read.
// ----------------------------------------------------------------------------
module bsws_ram #(
   parameter int  DEPTH = bsws_pkg::DEPTH_DEFAULT,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [AW-1:0]              wr_addr,
   input  logic [bsws_pkg::DATA_W-1:0] wr_data,
   input  logic [AW-1:0]              rd_addr,
   output logic [bsws_pkg::DATA_W-1:0] rd_data
);

   logic [bsws_pkg::DATA_W-1:0] mem [DEPTH];
   logic [bsws_pkg::DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/byte_stack_with_search_core.sv
// ----------------------------------------------------------------------------
// byte_stack_with_search_core
// Last-in first-out stack of bytes with push, pop, clear and a top-down find.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake            payload
//   req_      in         req_tvalid/tready    tuser: opcode, tdata: data_in
//   rsp_      out        rsp_tvalid/tready    tdata: read_data .. depth_count
//
// Push, clear, and pop or find on an empty stack are answered from the idle
// state. A pop passes through the pop state, as the entry memory has a
// registered read. A find walks the entries from the top down to the
// uppermost match (at most the depth) in the find state, with one memory
// read per cycle.
// Reset is synchronous and empties the stack at once; the entry memory is
// not cleared, as only entries below the fill count are ever read.
// One output register holds a result item; a new input item is taken while
// the sequencer is idle and that register is empty or being emptied.
// ----------------------------------------------------------------------------
module byte_stack_with_search_core #(
   parameter int DEPTH = bsws_pkg::DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_in
   input  logic [1:0]  req_tuser,   // [1:0] opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // [7:0] read_data, [9:8] status, [10] found,
                                    // [17:11] found_index, [25:18] depth_count,
                                    // [31:26] zero
);

   // Address width of the entry memory and width of the fill count, which
   // must also hold the full depth itself.
   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   // Sequencer and stack state.
   bsws_pkg::state_type state_ff, state_in;
   logic [CW-1:0]       fill_ff, fill_in;
   logic [AW-1:0]       idx_ff, idx_in;
   logic [7:0]          key_ff, key_in;

   // Output register.
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [7:0]             rd_ff, rd_in;
   bsws_pkg::status_type   stat_ff, stat_in;
   logic                   found_ff, found_in;
   logic [6:0]             fidx_ff, fidx_in;
   logic [7:0]             depth_ff, depth_in;
   logic                   load_rsp;

   // Memory port signals.
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [7:0]    wr_data;
   logic [AW-1:0] rd_addr;
   logic [7:0]    rd_data;

   // Derived values.
   bsws_pkg::op_type op;
   logic             req_accept;
   logic             rsp_free;
   logic             stack_full;
   logic             stack_empty;
   logic [CW-1:0]    fill_dec;
   logic [AW-1:0]    top_addr;
   logic             key_match;
   logic [31:0]      fill_wide;
   logic [31:0]      idx_wide;

   assign op          = bsws_pkg::op_type'(req_tuser);
   assign rsp_free    = !rsp_valid_ff || rsp_tready;
   assign req_tready  = (state_ff == bsws_pkg::ST_IDLE) && rsp_free;
   assign req_accept  = req_tvalid && req_tready;
   assign stack_full  = (fill_ff == CW'(DEPTH));
   assign stack_empty = (fill_ff == '0);
   assign fill_dec    = fill_ff - CW'(1);
   assign top_addr    = fill_dec[AW-1:0];
   assign key_match   = (rd_data == key_ff);

   // Reported depth and match index are the low bits of the internal values.
   assign fill_wide = 32'(fill_in);
   assign idx_wide  = 32'(idx_ff);

   bsws_ram #(
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bsws_pkg::ST_IDLE: begin
            if (req_accept && !stack_empty) begin
               if (op == bsws_pkg::OP_POP) begin
                  state_in = bsws_pkg::ST_POP;
               end else if (op == bsws_pkg::OP_FIND) begin
                  state_in = bsws_pkg::ST_FIND;
               end
            end
         end
         bsws_pkg::ST_POP: begin
            state_in = bsws_pkg::ST_IDLE;
         end
         bsws_pkg::ST_FIND: begin
            if (key_match || idx_ff == '0) begin
               state_in = bsws_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bsws_pkg::ST_IDLE;
         end
      endcase
   end

   // Datapath control, memory accesses and the result to be loaded.
   always_comb begin
      fill_in  = fill_ff;
      idx_in   = idx_ff;
      key_in   = key_ff;
      wr_en    = 1'b0;
      wr_addr  = fill_ff[AW-1:0];
      wr_data  = req_tdata;
      rd_addr  = idx_ff - AW'(1);
      load_rsp = 1'b0;
      rd_in    = '0;
      stat_in  = bsws_pkg::STAT_OK;
      found_in = 1'b0;
      fidx_in  = '0;
      unique case (state_ff)
         bsws_pkg::ST_IDLE: begin
            // A pop or a find starts by reading the top entry.
            rd_addr = top_addr;
            if (req_accept) begin
               unique case (op)
                  bsws_pkg::OP_PUSH: begin
                     load_rsp = 1'b1;
                     if (stack_full) begin
                        stat_in = bsws_pkg::STAT_FULL;
                     end else begin
                        wr_en   = 1'b1;
                        fill_in = fill_ff + CW'(1);
                     end
                  end
                  bsws_pkg::OP_POP: begin
                     if (stack_empty) begin
                        load_rsp = 1'b1;
                        stat_in  = bsws_pkg::STAT_EMPTY;
                     end else begin
                        fill_in = fill_dec;
                     end
                  end
                  bsws_pkg::OP_CLEAR: begin
                     load_rsp = 1'b1;
                     fill_in  = '0;
                  end
                  bsws_pkg::OP_FIND: begin
                     key_in = req_tdata;
                     if (stack_empty) begin
                        load_rsp = 1'b1;
                        stat_in  = bsws_pkg::STAT_EMPTY;
                     end else begin
                        idx_in = top_addr;
                     end
                  end
               endcase
            end
         end
         bsws_pkg::ST_POP: begin
            // The top entry read at acceptance is now on the memory output.
            load_rsp = 1'b1;
            rd_in    = rd_data;
         end
         bsws_pkg::ST_FIND: begin
            // The memory output holds the entry at idx_ff; the next one down
            // is read in the same cycle in case the walk goes on.
            if (key_match) begin
               load_rsp = 1'b1;
               found_in = 1'b1;
               fidx_in  = idx_wide[6:0];
            end else if (idx_ff == '0) begin
               load_rsp = 1'b1;
            end else begin
               idx_in = idx_ff - AW'(1);
            end
         end
         default: begin
            load_rsp = 1'b0;
         end
      endcase
   end

   assign depth_in = fill_wide[7:0];

   // The output register is empty or emptying whenever a result is loaded,
   // as an item is only taken under that condition and the sequencer works
   // on one item at a time.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bsws_pkg::ST_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      key_ff <= key_in;
      if (load_rsp) begin
         rd_ff    <= rd_in;
         stat_ff  <= stat_in;
         found_ff <= found_in;
         fidx_ff  <= fidx_in;
         depth_ff <= depth_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, depth_ff, fidx_ff, found_ff, stat_ff, rd_ff};

endmodule

>>> rtl/core/bsws_checker.sv
// ----------------------------------------------------------------------------
// bsws_checker
// Port-level checks of the byte stack core, bound to its top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bsws_checker #(
   parameter int DEPTH = bsws_pkg::DEPTH_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   logic       rsp_stall;
   logic       rsp_found;
   logic [1:0] rsp_status;
   logic [7:0] rsp_byte;
   logic [7:0] rsp_depth;
   logic [7:0] depth_full;

   assign rsp_stall  = rsp_tvalid && !rsp_tready;
   assign rsp_found  = rsp_tvalid && rsp_tdata[10];
   assign rsp_status = rsp_tdata[9:8];
   assign rsp_byte   = rsp_tdata[7:0];
   assign rsp_depth  = rsp_tdata[25:18];
   assign depth_full = 8'(DEPTH);

   // A stalled result item stays offered and unchanged.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid, "result dropped")
   `ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_stall, $stable(rsp_tdata), "result changed")

   // A dropped push is only reported with the stack at its full depth.
   `ASSERT_IMP(a_full_depth, clock, reset, rsp_tvalid && rsp_status == bsws_pkg::STAT_FULL,
      rsp_depth == depth_full, "full status without full depth")

   // A match is only reported by a successful find, which returns no byte.
   `ASSERT_IMP(a_found_ok, clock, reset, rsp_found,
      rsp_status == bsws_pkg::STAT_OK && rsp_byte == 8'd0, "match with bad status or data")

   // The reported depth never exceeds the stack size (checked for depths up to 255).
   `ASSERT_IMP(a_depth_range, clock, reset, rsp_tvalid,
      DEPTH > 255 || rsp_depth <= depth_full, "depth beyond stack size")

endmodule

bind byte_stack_with_search_core bsws_checker #(.DEPTH(DEPTH)) u_bsws_checker (.*);

>>> verif/tb_byte_stack_with_search_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_byte_stack_with_search_core
// Self-checking testbench of the byte stack with push, pop, clear and find.
// A directed table covers the empty, single, duplicate and full stack cases,
// and a random part follows with push bursts, finds of stored and absent
// bytes, pops down to empty, clears and fills up to full. Every accepted
// request item is run through a stack model kept in the testbench, and every
// response item is compared field by field with the oldest prediction. Both
// channels idle at random, and once the response side holds off for a long
// stretch so that the core backs up and stalls its request channel.
// ----------------------------------------------------------------------------
module tb_byte_stack_with_search_core;

   localparam int STACK_DEPTH   = bsws_pkg::DEPTH_DEFAULT;
   localparam int RESET_CYCLES  = 11;
   localparam int RANDOM_ITEMS  = 690;
   localparam int HOLD_CYCLES   = 300;
   // Longest find walks every entry, so the drain allows well over that.
   localparam int DRAIN_CYCLES  = 4 * STACK_DEPTH;
   localparam int LIMIT_CYCLES  = 1500000;
   localparam int REPORT_LIMIT  = 10;
   localparam int DIRECTED_ROWS = 27;

   // One response item, declared from the highest bits down so that a cast of
   // the low 26 bits of rsp_tdata lines the fields up.
   typedef struct packed {
      logic [7:0]           depth_count;
      logic [6:0]           found_index;
      logic                 found;
      bsws_pkg::status_type status;
      logic [7:0]           read_data;
   } stack_result_type;

   // One row of the directed table. A row with reps above one pushes a run of
   // bytes counting up from data. Where typed is set the response is given in
   // the row; otherwise it comes from the stack model.
   typedef struct packed {
      bsws_pkg::op_type op;
      logic [7:0]       data;
      int unsigned      reps;
      bit               typed;
      stack_result_type exp;
   } directed_row_type;

   // Expected responses in the order depth, index, found, status, read data.
   localparam directed_row_type DIRECTED_TABLE [DIRECTED_ROWS] = '{
      // Empty stack after reset.
      '{bsws_pkg::OP_POP, 8'h00, 1, 1'b1, '{8'd0, 7'd0, 1'b0, bsws_pkg::STAT_EMPTY, 8'h00}},
      '{bsws_pkg::OP_FIND, 8'h00, 1, 1'b1, '{8'd0, 7'd0, 1'b0, bsws_pkg::STAT_EMPTY, 8'h00}},
      '{bsws_pkg::OP_CLEAR, 8'h00, 1, 1'b1, '{8'd0, 7'd0, 1'b0, bsws_pkg::STAT_OK, 8'h00}},
      // Extreme bytes, their finds, a miss and a duplicate.
      '{bsws_pkg::OP_PUSH, 8'h00, 1, 1'b1, '{8'd1, 7'd0, 1'b0, bsws_pkg::STAT_OK, 8'h00}},
      '{bsws_pkg::OP_PUSH, 8'hFF, 1, 1'b1, '{8'd2, 7'd0, 1'b0, bsws_pkg::STAT_OK, 8'h00}},
      '{bsws_pkg::OP_FIND, 8'hFF, 1, 1'b1, '{8'd2, 7'd1, 1'b1, bsws_pkg::STAT_OK, 8'h00}},
      '{bsws_pkg::OP_FIND, 8'h00, 1, 1'b1, '{8'd2, 7'd0, 1'b1, bsws_pkg::STAT_OK, 8'h00}},
      '{bsws_pkg::OP_FIND, 8'h5A, 1, 1'b1, '{8'd2, 7'd0, 1'b0, bsws_pkg::STAT_OK, 8'h00}},
      '{bsws_pkg::OP_PUSH, 8'hFF, 1, 1'b1, '{8'd3, 7'd0, 1'b0, bsws_pkg::STAT_OK, 8'h00}},
      '{bsws_pkg::OP_FIND, 8'hFF, 1, 1'b1, '{8'd3, 7'd2, 1'b1, bsws_pkg::STAT_OK, 8'h00}},
      // Pop down to empty and once beyond.
      '{bsws_pkg::OP_POP, 8'h00, 1, 1'b1, '{8'd2, 7'd0, 1'b0, bsws_pkg::STAT_OK, 8'hFF}},
      '{bsws_pkg::OP_POP, 8'h00, 1, 1'b1, '{8'd1, 7'd0, 1'b0, bsws_pkg::STAT_OK, 8'hFF}},
      '{bsws_pkg::OP_POP, 8'h00, 1, 1'b1, '{8'd0, 7'd0, 1'b0, bsws_pkg::STAT_OK, 8'h00}},
      '{bsws_pkg::OP_POP, 8'h00, 1, 1'b1, '{8'd0, 7'd0, 1'b0, bsws_pkg::STAT_EMPTY, 8'h00}},
      // A cleared byte must not come back.
      '{bsws_pkg::OP_PUSH, 8'hA5, 1, 1'b0, '0},
      '{bsws_pkg::OP_CLEAR, 8'h00, 1, 1'b1, '{8'd0, 7'd0, 1'b0, bsws_pkg::STAT_OK, 8'h00}},
      '{bsws_pkg::OP_POP, 8'h00, 1, 1'b1, '{8'd0, 7'd0, 1'b0, bsws_pkg::STAT_EMPTY, 8'h00}},
      // Fill to the top, push into a full stack, then finds of the bottom and top entries and a miss.
      '{bsws_pkg::OP_PUSH, 8'h01, 128, 1'b0, '0},
      '{bsws_pkg::OP_PUSH, 8'h3C, 1, 1'b1, '{8'd128, 7'd0, 1'b0, bsws_pkg::STAT_FULL, 8'h00}},
      '{bsws_pkg::OP_PUSH, 8'hFF, 1, 1'b1, '{8'd128, 7'd0, 1'b0, bsws_pkg::STAT_FULL, 8'h00}},
      '{bsws_pkg::OP_FIND, 8'h01, 1, 1'b1, '{8'd128, 7'd0, 1'b1, bsws_pkg::STAT_OK, 8'h00}},
      '{bsws_pkg::OP_FIND, 8'h80, 1, 1'b1, '{8'd128, 7'd127, 1'b1, bsws_pkg::STAT_OK, 8'h00}},
      '{bsws_pkg::OP_FIND, 8'hC3, 1, 1'b1, '{8'd128, 7'd0, 1'b0, bsws_pkg::STAT_OK, 8'h00}},
      '{bsws_pkg::OP_POP, 8'h00, 1, 1'b1, '{8'd127, 7'd0, 1'b0, bsws_pkg::STAT_OK, 8'h80}},
      '{bsws_pkg::OP_PUSH, 8'h7E, 1, 1'b0, '0},
      '{bsws_pkg::OP_FIND, 8'h7E, 1, 1'b0, '0},
      '{bsws_pkg::OP_CLEAR, 8'h00, 1, 1'b1, '{8'd0, 7'd0, 1'b0, bsws_pkg::STAT_OK, 8'h00}}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;              // [7:0] data_in
   logic [1:0]  req_tuser = bsws_pkg::OP_PUSH;  // [1:0] opcode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;            // [7:0] read_data, [9:8] status, [10] found,
                                      // [17:11] found_index, [25:18] depth_count

   // Stack model: its own copy of the entries and the fill count.
   logic [7:0]       stack_mem [STACK_DEPTH];
   int unsigned      stack_fill = 0;
   stack_result_type expected_results [$];

   int unsigned items_sent     = 0;
   int unsigned mismatch_count = 0;
   // While set, neither side idles; set for bursts at the full rate.
   bit          no_idle        = 1'b0;
   // Asks the response side for one long hold-off.
   bit          hold_request   = 1'b0;

   byte_stack_with_search_core #(
      .DEPTH (STACK_DEPTH)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // Applies one operation to the stack model and returns the response that it
   // must produce. Find walks from the top down and keeps the first match.
   function automatic stack_result_type stack_apply(bsws_pkg::op_type op,
                                                    logic [7:0] value);
      stack_result_type res;
      res = '0;
      res.status = bsws_pkg::STAT_OK;
      case (op)
         bsws_pkg::OP_PUSH: begin
            if (stack_fill >= STACK_DEPTH) begin
               res.status = bsws_pkg::STAT_FULL;
            end else begin
               stack_mem[stack_fill] = value;
               stack_fill++;
            end
         end
         bsws_pkg::OP_POP: begin
            if (stack_fill == 0) begin
               res.status = bsws_pkg::STAT_EMPTY;
            end else begin
               stack_fill--;
               res.read_data = stack_mem[stack_fill];
            end
         end
         bsws_pkg::OP_CLEAR: begin
            stack_fill = 0;
         end
         default: begin
            if (stack_fill == 0) begin
               res.status = bsws_pkg::STAT_EMPTY;
            end else begin
               for (int i = int'(stack_fill) - 1; i >= 0; i--) begin
                  if (!res.found && stack_mem[i] == value) begin
                     res.found       = 1'b1;
                     res.found_index = 7'(i);
                  end
               end
            end
         end
      endcase
      res.depth_count = 8'(stack_fill);
      return res;
   endfunction

   // Length of one idle stretch: mostly short, now and then long.
   function automatic int unsigned idle_length();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70) begin
         return $urandom_range(1, 3);
      end else if (r < 95) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 80);
   endfunction

   // Random byte, half of the time from a narrow set so that the stack holds
   // duplicates and finds meet more than one candidate.
   function automatic logic [7:0] pick_byte();
      if ($urandom_range(0, 1) == 0) begin
         return 8'($urandom_range(0, 255));
      end
      return 8'h40 + 8'($urandom_range(0, 7));
   endfunction

   // Offers one request item after a random gap and waits until it is taken.
   // The prediction is made at the edge of acceptance, from the model state
   // left by all earlier items.
   task automatic offer_item(bsws_pkg::op_type op, logic [7:0] value, bit typed,
                             stack_result_type typed_exp);
      int unsigned      gap;
      stack_result_type predicted;
      gap = 0;
      if (!no_idle && $urandom_range(0, 99) >= 55) begin
         gap = idle_length();
      end
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= value;
      do begin
         @(posedge clock);
      end while (!req_tready);
      predicted = stack_apply(op, value);
      expected_results.push_back(typed ? typed_exp : predicted);
      items_sent++;
   endtask

   // Response side: random stalls, plus one long hold-off on request, counted
   // here in cycles while the request side keeps offering items.
   initial begin
      int unsigned stall_left;
      int unsigned hold_left;
      stall_left = 0;
      hold_left  = 0;
      forever begin
         @(posedge clock);
         if (hold_left != 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES - 1;
            rsp_tready   <= 1'b0;
         end else if (stall_left != 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else if (!no_idle && $urandom_range(0, 99) < 25) begin
            stall_left = idle_length() - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Checks each accepted response item against the oldest prediction.
   always @(posedge clock) begin
      stack_result_type got;
      stack_result_type exp;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = stack_result_type'(rsp_tdata[25:0]);
         if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
               $display("unexpected response item: rsp_tdata=%h", rsp_tdata);
            end
         end else begin
            exp = expected_results.pop_front();
            if (got.read_data !== exp.read_data || got.status !== exp.status ||
                got.found !== exp.found || got.found_index !== exp.found_index ||
                got.depth_count !== exp.depth_count) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("mismatch: read_data %h/%h status %0d/%0d found %0d/%0d",
                           exp.read_data, got.read_data, exp.status, got.status,
                           exp.found, got.found);
                  $display("          found_index %0d/%0d depth_count %0d/%0d",
                           exp.found_index, got.found_index,
                           exp.depth_count, got.depth_count);
               end
            end
         end
      end
   end

   // Watchdog on the whole run.
   initial begin
      repeat (LIMIT_CYCLES) @(posedge clock);
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      int unsigned      n;
      int unsigned      scenario;
      int unsigned      random_target;
      bit               hold_done;
      directed_row_type row;

      hold_done = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed part: walk the table.
      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         row = DIRECTED_TABLE[r];
         for (int k = 0; k < int'(row.reps); k++) begin
            offer_item(row.op, 8'(row.data + k), row.typed, row.exp);
         end
      end

      // Random part: mostly well-formed sequences with random content, with
      // some plain noise between them.
      random_target = items_sent + RANDOM_ITEMS;
      while (items_sent < random_target) begin
         no_idle  = ($urandom_range(0, 99) < 12);
         scenario = $urandom_range(0, 99);
         if (!hold_done && items_sent + RANDOM_ITEMS > random_target + 200) begin
            // The response side stops for a long while; the core fills its
            // output register and must refuse further request items.
            hold_done    = 1'b1;
            hold_request = 1'b1;
            no_idle      = 1'b1;
            for (int k = 0; k < 12; k++) begin
               offer_item(($urandom_range(0, 1) == 0) ? bsws_pkg::OP_PUSH
                                                      : bsws_pkg::OP_FIND,
                          pick_byte(), 1'b0, '0);
            end
         end else if (scenario < 30) begin
            n = $urandom_range(1, 16);
            for (int k = 0; k < int'(n); k++) begin
               offer_item(bsws_pkg::OP_PUSH, pick_byte(), 1'b0, '0);
            end
         end else if (scenario < 45) begin
            // Find of a byte that is stored somewhere in the stack.
            if (stack_fill != 0) begin
               offer_item(bsws_pkg::OP_FIND,
                          stack_mem[$urandom_range(0, stack_fill - 1)], 1'b0, '0);
            end else begin
               offer_item(bsws_pkg::OP_FIND, pick_byte(), 1'b0, '0);
            end
         end else if (scenario < 55) begin
            offer_item(bsws_pkg::OP_FIND, 8'($urandom_range(0, 255)), 1'b0, '0);
         end else if (scenario < 70) begin
            n = $urandom_range(1, 8);
            for (int k = 0; k < int'(n); k++) begin
               offer_item(bsws_pkg::OP_POP, 8'($urandom_range(0, 255)), 1'b0, '0);
            end
         end else if (scenario < 74) begin
            offer_item(bsws_pkg::OP_CLEAR, 8'($urandom_range(0, 255)), 1'b0, '0);
         end else if (scenario < 77) begin
            // Fill to the top and push a few more into the full stack.
            n = STACK_DEPTH - stack_fill + $urandom_range(1, 3);
            for (int k = 0; k < int'(n); k++) begin
               offer_item(bsws_pkg::OP_PUSH, pick_byte(), 1'b0, '0);
            end
            offer_item(bsws_pkg::OP_FIND, pick_byte(), 1'b0, '0);
         end else if (scenario < 80) begin
            // Pop down to empty and a little beyond.
            n = stack_fill + $urandom_range(1, 2);
            for (int k = 0; k < int'(n); k++) begin
               offer_item(bsws_pkg::OP_POP, 8'($urandom_range(0, 255)), 1'b0, '0);
            end
         end else begin
            n = $urandom_range(1, 4);
            for (int k = 0; k < int'(n); k++) begin
               offer_item(bsws_pkg::op_type'($urandom_range(0, 3)),
                          8'($urandom_range(0, 255)), 1'b0, '0);
            end
         end
      end
      req_tvalid <= 1'b0;
      no_idle    = 1'b0;

      // Drain, then let the core run on in case it sends something extra.
      while (expected_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/bsws_pkg.sv
rtl/core/bsws_ram.sv
rtl/core/byte_stack_with_search_core.sv
rtl/core/bsws_checker.sv
verif/tb_byte_stack_with_search_core.sv
